// ===== hw/rtl/gcb_pkg.sv =====
// Shared types, constants and arctangent table for the bearing pipeline.
package gcb_pkg;

  localparam int CordicStepsDef = 24;

  // Full turn in coordinate units and the rounding offset added below the binary point.
  localparam logic [31:0] UnitsPerTurn = 32'd3600000000;
  localparam logic [31:0] HalfTurnUnits = 32'd1800000000;
  // floor(2^64 / UnitsPerTurn) - 2^32
  localparam logic [31:0] RecipFrac = 32'd829128280;
  localparam int ConvStages = 4;

  localparam logic signed [32:0] Q30One = 33'sd1073741824;
  localparam logic signed [32:0] GainQ30 = 33'sd652032874;

  localparam int RotW = 33;
  localparam int VecW = 36;

  typedef struct packed {
    logic signed [RotW-1:0] x;
    logic signed [RotW-1:0] y;
    logic signed [RotW-1:0] z;
    logic [1:0]             quad;
    logic                   zero;
  } rot_t;

  typedef struct packed {
    logic signed [VecW-1:0] u;
    logic signed [VecW-1:0] v;
    logic [31:0]            z;
    logic                   xzero;
    logic                   yneg;
  } vec_t;

  // atan(2^-i) as a binary angle, 2^32 = one turn
  function automatic logic [31:0] atan_at(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'd536870912;
      1: r = 32'd316933406;
      2: r = 32'd167458907;
      3: r = 32'd85004756;
      4: r = 32'd42667331;
      5: r = 32'd21354465;
      6: r = 32'd10679838;
      7: r = 32'd5340245;
      8: r = 32'd2670163;
      9: r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/gcb_div_cell.sv =====
// Coordinate to binary angle conversion: reciprocal multiply with a one-step correction.
module gcb_div_cell import gcb_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] rem_i,  // reduced coordinate, 0..UnitsPerTurn-1
  output logic [31:0] quo_o   // rem_i * 2^32 / UnitsPerTurn, rounded half up
);

  logic [63:0] frac_d, frac_q, round_sum;
  logic [31:0] r1_q, est_d, est_q, est3_q, quo_d, quo_q;
  logic [1:0]  r2_q, r3_q;
  logic [33:0] back_d, back_q, num, rem;

  // r * 2^64/D = r * 2^32 + r * RecipFrac; the estimate is low by at most one
  assign frac_d    = {32'd0, rem_i} * {32'd0, RecipFrac};
  assign round_sum = frac_q + 64'h0000_0000_8000_0000;
  assign est_d     = r1_q + round_sum[63:32];
  // remainder lies in 0..2*D-1, so its low 34 bits are enough
  assign back_d    = {2'b00, est_q} * {2'b00, UnitsPerTurn};
  assign num       = {r3_q, 32'd0} + {2'b00, HalfTurnUnits};
  assign rem       = num - back_q;
  assign quo_d     = (rem >= {2'b00, UnitsPerTurn}) ? est3_q + 32'd1 : est3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      frac_q <= frac_d;
      r1_q   <= rem_i;
      est_q  <= est_d;
      r2_q   <= r1_q[1:0];
      back_q <= back_d;
      est3_q <= est_q;
      r3_q   <= r2_q;
      quo_q  <= quo_d;
    end
  end

  assign quo_o = quo_q;

endmodule

// ===== hw/rtl/gcb_rot_cell.sv =====
// One CORDIC rotation step for sine and cosine.
module gcb_rot_cell import gcb_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic clk_i,
  input  logic en_i,
  input  rot_t d_i,
  output rot_t q_o
);

  localparam logic signed [RotW-1:0] Atan = RotW'(atan_at(STEP));

  rot_t cell_d, cell_q;

  always_comb begin
    cell_d = d_i;
    if (!d_i.zero) begin
      if (d_i.z >= 0) begin
        cell_d.x = d_i.x - (d_i.y >>> STEP);
        cell_d.y = d_i.y + (d_i.x >>> STEP);
        cell_d.z = d_i.z - Atan;
      end else begin
        cell_d.x = d_i.x + (d_i.y >>> STEP);
        cell_d.y = d_i.y - (d_i.x >>> STEP);
        cell_d.z = d_i.z + Atan;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

// ===== hw/rtl/gcb_vec_cell.sv =====
// One CORDIC vectoring step for atan2.
module gcb_vec_cell import gcb_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic clk_i,
  input  logic en_i,
  input  vec_t d_i,
  output vec_t q_o
);

  localparam logic [31:0] Atan = atan_at(STEP);

  vec_t cell_d, cell_q;

  always_comb begin
    cell_d = d_i;
    if (d_i.v > 0) begin
      cell_d.u = d_i.u + (d_i.v >>> STEP);
      cell_d.v = d_i.v - (d_i.u >>> STEP);
      cell_d.z = d_i.z + Atan;
    end else begin
      cell_d.u = d_i.u - (d_i.v >>> STEP);
      cell_d.v = d_i.v + (d_i.u >>> STEP);
      cell_d.z = d_i.z - Atan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

// ===== hw/rtl/great_circle_bearing_unit.sv =====
// Great-circle initial bearing unit: top level with the full pipeline and stream ports.
//
// Takes own and target positions (lat/lon, signed, 1e-7 degree) and returns the
// initial great-circle bearing, whole degrees 0..359 clockwise from north
// (angle truncated toward zero, then wrapped; identical points give 0).
// Fully pipelined: one transfer per cycle in and out unless the output stalls. A result
// reaches the output register through the four-stage reciprocal conversion of the
// coordinates to binary angles, the quadrant split register, the CORDIC_STEPS
// sine/cosine rotation cells, two multiply stages and the north-component stage, the
// CORDIC_STEPS atan2 vectoring cells, the degree scaling and the output register.
// The whole pipe advances while the output register is empty or being taken, so
// s_tready_o follows m_tready_i when a result is held.
module great_circle_bearing_unit import gcb_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  // own_latitude[30:0], own_longitude[62:31], target_latitude[93:63],
  // target_longitude[125:94], zero pad [127:126]
  input  logic [127:0] s_tdata_i,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // bearing_degrees[8:0], zero pad [15:9]
  output logic [15:0]  m_tdata_o
);

  localparam int Lat = ConvStages + 5 + 2 * CORDIC_STEPS;

  logic en;
  logic [Lat-1:0] vld_q;
  logic           out_vld_q;
  logic [8:0]     bearing_q, bearing_d;

  assign en = !out_vld_q || m_tready_i;
  assign s_tready_o = en;

  // ---- valid chain and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[Lat-2:0], s_tvalid_i};
      out_vld_q <= vld_q[Lat-1];
    end
  end

  // ---- coordinate reduction into 0..3599999999, then binary angle
  logic [31:0] coord [4];
  logic [31:0] turn  [4];

  assign coord[0] = {s_tdata_i[30], s_tdata_i[30:0]};
  assign coord[1] = s_tdata_i[62:31];
  assign coord[2] = {s_tdata_i[93], s_tdata_i[93:63]};
  assign coord[3] = s_tdata_i[125:94];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [32:0] wrapped;
    logic [31:0] reduced;
    assign wrapped = {coord[l][31], coord[l]} + {1'b0, UnitsPerTurn};
    assign reduced = coord[l][31] ? wrapped[31:0] : coord[l];
    gcb_div_cell u_conv (
      .clk_i(clk_i), .en_i(en), .rem_i(reduced), .quo_o(turn[l])
    );
  end

  // ---- quadrant split: lanes are lat1, lat2, dlon
  logic [31:0] ang [3];
  rot_t        rot_c [3][CORDIC_STEPS+1];
  rot_t        rot_d [3];

  assign ang[0] = turn[0];
  assign ang[1] = turn[2];
  assign ang[2] = turn[3] - turn[1];

  for (genvar l = 0; l < 3; l++) begin : g_rot
    logic [31:0] biased, rb;
    rot_t        prep_q;
    always_comb begin
      biased         = ang[l] + 32'h2000_0000;
      rb             = ang[l] - {biased[31:30], 30'd0};
      rot_d[l].quad  = biased[31:30];
      rot_d[l].zero  = (rb == '0);
      rot_d[l].z     = RotW'($signed(rb));
      rot_d[l].x     = rot_d[l].zero ? Q30One : GainQ30;
      rot_d[l].y     = '0;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        prep_q <= rot_d[l];
      end
    end
    assign rot_c[l][0] = prep_q;
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      gcb_rot_cell #(.STEP(k)) u_cell (
        .clk_i(clk_i), .en_i(en), .d_i(rot_c[l][k]), .q_o(rot_c[l][k+1])
      );
    end
  end

  // ---- quadrant fold to cos/sin
  logic signed [RotW-1:0] cosv [3];
  logic signed [RotW-1:0] sinv [3];

  for (genvar l = 0; l < 3; l++) begin : g_fold
    rot_t r;
    assign r = rot_c[l][CORDIC_STEPS];
    always_comb begin
      case (r.quad)
        2'd0: begin cosv[l] = r.x;  sinv[l] = r.y;  end
        2'd1: begin cosv[l] = -r.y; sinv[l] = r.x;  end
        2'd2: begin cosv[l] = -r.x; sinv[l] = -r.y; end
        default: begin cosv[l] = r.y; sinv[l] = -r.x; end
      endcase
    end
  end

  // ---- stage A: cos2*sin(dl), cos2*cos(dl)
  logic signed [65:0]     pcs_q, pcc_q;
  logic signed [RotW-1:0] c1_a_q, s1_a_q, s2_a_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pcs_q  <= cosv[1] * sinv[2];
      pcc_q  <= cosv[1] * cosv[2];
      c1_a_q <= cosv[0];
      s1_a_q <= sinv[0];
      s2_a_q <= sinv[1];
    end
  end

  // ---- stage B: cos1*sin2, sin1*p
  logic signed [RotW-1:0] p_b, xe_b;
  logic signed [65:0]     m1_q, m2_q;
  logic signed [RotW-1:0] xe_q;

  assign p_b  = pcc_q[62:30];
  assign xe_b = pcs_q[62:30];

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q <= c1_a_q * s2_a_q;
      m2_q <= s1_a_q * p_b;
      xe_q <= xe_b;
    end
  end

  // ---- stage C: north component, vectoring start with half-plane fold
  logic signed [65:0]     diff;
  logic signed [VecW-1:0] yn, xe_w;
  vec_t                   vec_d, vec_init_q;
  vec_t                   vec_c [CORDIC_STEPS+1];

  always_comb begin
    diff        = m1_q - m2_q;
    yn          = diff[65:30];
    xe_w        = VecW'(xe_q);
    vec_d.xzero = (xe_q == '0);
    vec_d.yneg  = yn[VecW-1];
    if (yn[VecW-1]) begin
      vec_d.u = -yn;
      vec_d.v = -xe_w;
      vec_d.z = 32'h8000_0000;
    end else begin
      vec_d.u = yn;
      vec_d.v = xe_w;
      vec_d.z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vec_init_q <= vec_d;
    end
  end

  assign vec_c[0] = vec_init_q;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
    gcb_vec_cell #(.STEP(k)) u_cell (
      .clk_i(clk_i), .en_i(en), .d_i(vec_c[k]), .q_o(vec_c[k+1])
    );
  end

  // ---- stage M: binary angle to whole degrees, truncated toward zero
  vec_t        vf;
  logic [31:0] mag_ang;
  logic [40:0] deg_prod;
  logic [8:0]  mag_q;
  logic        neg_q, xzero_q, yneg_q;

  assign vf       = vec_c[CORDIC_STEPS];
  assign mag_ang  = vf.z[31] ? (32'd0 - vf.z) : vf.z;
  assign deg_prod = {9'd0, mag_ang} * 41'd360;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q   <= deg_prod[40:32];
      neg_q   <= vf.z[31];
      xzero_q <= vf.xzero;
      yneg_q  <= vf.yneg;
    end
  end

  // ---- wrap into 0..359; a pure north/south vector bypasses atan2
  always_comb begin
    if (xzero_q) begin
      bearing_d = yneg_q ? 9'd180 : 9'd0;
    end else if (neg_q && mag_q != '0) begin
      bearing_d = 9'd360 - mag_q;
    end else begin
      bearing_d = mag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bearing_q <= bearing_d;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = {7'd0, bearing_q};

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the great-circle initial bearing unit.
`timescale 1ns / 1ps

module testbench;
  import gcb_pkg::*;

  localparam int Steps = CordicStepsDef;
  localparam int HalfPeriod = 4;
  localparam int IdleLimit = 20000;
  localparam int RandomItems = 1600;
  localparam int DrainCycles = 200;
  localparam longint TurnUnits = 64'd3600000000;
  localparam int LatMax = 900000000;
  localparam int LonMax = 1800000000;

  // arctangent of 2^-i as a binary angle, 2^32 per turn
  localparam logic [31:0] ArctanTurn [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [31:0] tgt_lon;
    logic signed [30:0] tgt_lat;
    logic signed [31:0] own_lon;
    logic signed [30:0] own_lat;
  } position_pair_t;

  // Bearing scoreboard: predicts each accepted pair, checks results in order.
  class bearing_board;
    logic [8:0] pending_bearings[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    // coordinate in 1e-7 degree to binary angle, round half up
    function logic [31:0] units_to_turn(longint v);
      longint r;
      longint unsigned q;
      r = v % TurnUnits;
      if (r < 0) r += TurnUnits;
      q = ((longint'(r) << 32) + 64'd1800000000) / TurnUnits;
      return q[31:0];
    endfunction

    function void rotate(logic [31:0] a, output longint c, output longint s);
      logic [31:0] quad, resid;
      longint z, x, y, nx;
      quad = ((a + 32'h2000_0000) >> 30) & 32'd3;
      resid = a - (quad << 30);
      z = longint'($signed(resid));
      x = 652032874;
      y = 0;
      if (z == 0) begin
        x = 64'd1073741824;
      end else begin
        for (int i = 0; i < Steps; i++) begin
          if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= longint'(ArctanTurn[i]);
          end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += longint'(ArctanTurn[i]);
          end
          x = nx;
        end
      end
      case (quad[1:0])
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    // vectoring: angle of (north u, east v)
    function logic [31:0] heading_turn(longint u, longint v);
      logic [31:0] z;
      longint nu;
      z = '0;
      if (u < 0) begin
        u = -u;
        v = -v;
        z = 32'h8000_0000;
      end
      for (int i = 0; i < Steps; i++) begin
        if (v > 0) begin
          nu = u + (v >>> i);
          v = v - (u >>> i);
          z += ArctanTurn[i];
        end else begin
          nu = u - (v >>> i);
          v = v + (u >>> i);
          z -= ArctanTurn[i];
        end
        u = nu;
      end
      return z;
    endfunction

    function logic [8:0] predict_bearing(position_pair_t p);
      logic [31:0] dlon, z;
      longint c1, s1, c2, s2, cd, sd, east, prod, north, sz, mag, deg;
      dlon = units_to_turn(longint'(p.tgt_lon)) - units_to_turn(longint'(p.own_lon));
      rotate(units_to_turn(longint'(p.own_lat)), c1, s1);
      rotate(units_to_turn(longint'(p.tgt_lat)), c2, s2);
      rotate(dlon, cd, sd);
      east = (c2 * sd) >>> 30;
      prod = (c2 * cd) >>> 30;
      north = (c1 * s2 - s1 * prod) >>> 30;
      // no east component: due north or due south
      if (east == 0) return (north >= 0) ? 9'd0 : 9'd180;
      z = heading_turn(north, east);
      sz = longint'($signed(z));
      // truncate toward zero, then wrap
      if (sz >= 0) begin
        mag = (sz * 360) >>> 32;
        deg = mag;
      end else begin
        mag = ((-sz) * 360) >>> 32;
        deg = -mag;
      end
      deg = (deg + 360) % 360;
      return deg[8:0];
    endfunction

    function void note_pair(position_pair_t p);
      pending_bearings.push_back(predict_bearing(p));
    endfunction

    function void check_bearing(logic [15:0] data);
      logic [8:0] want;
      if (pending_bearings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: bearing %0d", data[8:0]);
        return;
      end
      want = pending_bearings.pop_front();
      if (data[8:0] !== want || data[15:9] !== 7'd0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("bearing mismatch: expected %0d, got %0d (pad %h)", want, data[8:0],
                   data[15:9]);
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_tvalid_i;
  logic         s_tready_o;
  logic [127:0] s_tdata_i;
  logic         m_tvalid_o;
  logic         m_tready_i;
  logic [15:0]  m_tdata_o;

  bearing_board board;
  int           idle_cycles;

  great_circle_bearing_unit #(
    .CORDIC_STEPS(Steps)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o)
  );

  initial clk_i = 1'b0;
  always #(HalfPeriod) clk_i = ~clk_i;

  // Monitors: every transfer is seen with the values present at the edge.
  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid_i && s_tready_o) board.note_pair(position_pair_t'(s_tdata_i[125:0]));
    if (rst_ni && m_tvalid_o && m_tready_i) board.check_bearing(m_tdata_o);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Sender state for bursts: remaining items in the burst.
  int burst_left;

  // Offer one pair; valid stays high inside a burst, may drop for a random gap after.
  task automatic send_pair(position_pair_t p);
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {2'b00, p};
    do @(posedge clk_i); while (!s_tready_o);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(0, 40);
      if (gap > 0) begin
        s_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic position_pair_t make_pair(int olat, int olon, int tlat, int tlon);
    position_pair_t p;
    p.own_lat = olat[30:0];
    p.own_lon = olon;
    p.tgt_lat = tlat[30:0];
    p.tgt_lon = tlon;
    return p;
  endfunction

  function automatic int pick_lat();
    case ($urandom_range(0, 5))
      0: return int'($urandom()) >>> 1;              // any 31-bit pattern
      1: return $urandom_range(0, 1) ? LatMax : -LatMax;
      2: return $urandom_range(0, 2) * 450000000 - 450000000;
      default: return int'($urandom_range(0, 2 * LatMax)) - LatMax;
    endcase
  endfunction

  function automatic int pick_lon();
    case ($urandom_range(0, 5))
      0: return int'($urandom());
      1: return $urandom_range(0, 1) ? LonMax : -LonMax;
      2: return $urandom_range(0, 4) * 900000000 - LonMax;
      default: return int'($urandom_range(0, 2 * LonMax)) - LonMax;
    endcase
  endfunction

  function automatic position_pair_t random_pair();
    int olat, olon;
    olat = pick_lat();
    olon = pick_lon();
    case ($urandom_range(0, 4))
      // nearby target: small offsets expose truncation near 0 and 180
      0: return make_pair(olat, olon, olat + int'($urandom_range(0, 2000)) - 1000,
                          olon + int'($urandom_range(0, 2000)) - 1000);
      // same meridian or same point
      1: return make_pair(olat, olon, $urandom_range(0, 1) ? olat : pick_lat(), olon);
      default: return make_pair(olat, olon, pick_lat(), pick_lon());
    endcase
  endfunction

  // Receiver: switches among random stall patterns, with one long hold-off.
  initial begin
    int cyc, mode;
    m_tready_i <= 1'b0;
    cyc = 0;
    mode = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (cyc >= 2000 && cyc < 2600) m_tready_i <= 1'b0;
      else case (mode)
        0: m_tready_i <= 1'b1;
        1: m_tready_i <= $urandom_range(0, 1);
        2: m_tready_i <= $urandom_range(0, 7) != 0;
        default: m_tready_i <= $urandom_range(0, 3) == 0;
      endcase
    end
  end

  initial begin
    position_pair_t directed[$];
    board = new();
    s_tvalid_i <= 1'b0;
    s_tdata_i  <= '0;
    rst_ni     <= 1'b0;
    burst_left = 8;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back(make_pair(0, 0, 0, 0));                          // identical points
    directed.push_back(make_pair(LatMax, LonMax, LatMax, LonMax));
    directed.push_back(make_pair(0, 0, 100000000, 0));                  // due north
    directed.push_back(make_pair(0, 0, -100000000, 0));                 // due south
    directed.push_back(make_pair(0, 0, 0, 900000000));                  // quadrant angles
    directed.push_back(make_pair(0, 0, 0, -900000000));
    directed.push_back(make_pair(-LatMax, -LonMax, LatMax, LonMax));    // pole to pole
    directed.push_back(make_pair(LatMax, 0, 0, 0));
    directed.push_back(make_pair(-LatMax, 0, 0, 0));
    directed.push_back(make_pair(0, -LonMax, 0, LonMax));
    directed.push_back(make_pair(450000000, 0, 450000000, 900000000));
    directed.push_back(make_pair(0, 0, 15000, -1000));                  // slightly west of north
    directed.push_back(make_pair(0, 0, -15000, -1000));
    directed.push_back(make_pair(0, 0, 1, -1));
    directed.push_back(make_pair(0, 0, 0, 1));
    directed.push_back(make_pair(32'h3FFF_FFFF, 32'h7FFF_FFFF, 32'h4000_0000,
                                 32'h8000_0000));                       // out-of-range extremes
    directed.push_back(make_pair(32'h4000_0000, 32'h8000_0000, 32'h3FFF_FFFF,
                                 32'h7FFF_FFFF));
    directed.push_back(make_pair(-1, -1, -1, -1));
    directed.push_back(make_pair(512345678, -1234567890, -876543210, 1765432109));
    foreach (directed[i]) send_pair(directed[i]);

    for (int n = 0; n < RandomItems; n++) send_pair(random_pair());
    s_tvalid_i <= 1'b0;

    while (board.pending_bearings.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_bearings.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== great_circle_bearing_unit.f =====
hw/rtl/gcb_pkg.sv
hw/rtl/gcb_div_cell.sv
hw/rtl/gcb_rot_cell.sv
hw/rtl/gcb_vec_cell.sv
hw/rtl/great_circle_bearing_unit.sv
bench/testbench.sv
